/* hw/rtl/ipd_fd_pkg.sv */
// Types and character constants for the +IPD frame demultiplexer.
package ipd_fd_pkg;

   localparam int WINDOW_BYTES = 4;

   // "+IPD" as it sits in the window, newest byte lowest
   localparam logic [31:0] PREFIX_HEAD = 32'h2B49_5044;
   localparam logic [7:0]  PREFIX_TAIL = 8'h2C;   // ','
   localparam logic [7:0]  COLON_CHAR  = 8'h3A;   // ':'
   localparam logic [7:0]  DIGIT_ZERO  = 8'h30;   // '0'
   localparam logic [7:0]  DIGIT_NINE  = 8'h39;   // '9'

   localparam int PLEN_BITS = 16;

   typedef enum logic [1:0] {
      ROUTE_TEXT    = 2'd0,
      ROUTE_PAYLOAD = 2'd1,
      ROUTE_HEADER  = 2'd2
   } route_type;

   typedef struct packed {
      logic [PLEN_BITS-1:0] payload_length;
      logic                 header_done;
      logic                 payload_last;
      route_type            route;
      logic [7:0]           data_byte;
   } rsp_type;

endpackage

/* hw/rtl/ipd_frame_demux_core.sv */
// Top level of the +IPD frame demultiplexer: header parser, payload counter, output buffer.
//
// Splits a received modem byte stream into response text, "+IPD,<len>:" header bytes
// and payload bytes, one result beat per input beat. A new byte is accepted every clock
// cycle while the skid entry is free; each result is registered before the rsp_ side.
// The parser state (prefix window, length accumulator, payload counter) updates in the
// same cycle the byte is taken, so the per-byte rate is set by that update with one
// constant multiply-add by ten. A result register plus one skid entry decouple the two
// sides: req_tready drops only when both are occupied. The first four prefix bytes pass
// as text, the comma, digits and colon are tagged as header bytes, and a nonzero length
// routes that many following bytes as payload with tlast on the final one. The length
// saturates at 2**LENGTH_BITS-1; digits past MAX_DIGITS are ignored.
module ipd_frame_demux_core
   import ipd_fd_pkg::*;
#(
   parameter int MAX_DIGITS  = 15,
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [23:8] payload_length
   output logic [2:0]  rsp_tuser,   // [1:0] route, [2] header_done
   output logic        rsp_tlast    // payload_last
);

   localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
   localparam int MAC_W  = LENGTH_BITS + 4;

   logic [31:0]            window_ff, window_in;
   logic [2:0]             fill_ff, fill_in;
   logic                   in_len_ff, in_len_in;
   logic [DCNT_W-1:0]      digit_cnt_ff, digit_cnt_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   pay_active_ff, pay_active_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   rsp_type          result;
   logic             in_take;
   logic             rsp_take;
   logic [MAC_W-1:0] mac_ext;
   logic [MAC_W-1:0] mac;
   logic [3:0]       digit_val;

   assign req_tready = ~skid_valid_ff;
   assign in_take    = req_tvalid & req_tready;
   assign rsp_take   = rsp_tvalid & rsp_tready;

   assign digit_val = 4'(req_tdata - DIGIT_ZERO);
   assign mac_ext   = MAC_W'(length_ff);
   assign mac       = (mac_ext << 3) + (mac_ext << 1) + MAC_W'(digit_val);

   // Parser: one byte in, one result out, next state
   always_comb begin
      window_in     = window_ff;
      fill_in       = fill_ff;
      in_len_in     = in_len_ff;
      digit_cnt_in  = digit_cnt_ff;
      length_in     = length_ff;
      pay_active_in = pay_active_ff;
      remain_in     = remain_ff;

      result                = '0;
      result.data_byte      = req_tdata;
      result.route          = ROUTE_TEXT;

      if (pay_active_ff) begin
         result.route = ROUTE_PAYLOAD;
         if (remain_ff != '0) begin
            remain_in = remain_ff - LENGTH_BITS'(1);
         end
         // last when the count is one, or already zero
         if (remain_ff[LENGTH_BITS-1:1] == '0) begin
            pay_active_in       = 1'b0;
            result.payload_last = 1'b1;
         end
      end else if (in_len_ff) begin
         result.route = ROUTE_HEADER;
         if (req_tdata == COLON_CHAR) begin
            result.header_done    = 1'b1;
            result.payload_length = PLEN_BITS'(length_ff);
            remain_in             = length_ff;
            pay_active_in         = (length_ff != '0);
            in_len_in             = 1'b0;
            window_in             = '0;
            fill_in               = '0;
         end else if (req_tdata inside {[DIGIT_ZERO:DIGIT_NINE]}) begin
            if (digit_cnt_ff < DCNT_W'(MAX_DIGITS)) begin
               // saturate on overflow
               length_in    = (mac[MAC_W-1:LENGTH_BITS] != '0) ? '1
                                                               : mac[LENGTH_BITS-1:0];
               digit_cnt_in = digit_cnt_ff + DCNT_W'(1);
            end
         end else begin
            // abort the header
            in_len_in = 1'b0;
            window_in = '0;
            fill_in   = '0;
         end
      end else begin
         if (fill_ff >= 3'(WINDOW_BYTES) && window_ff == PREFIX_HEAD &&
             req_tdata == PREFIX_TAIL) begin
            result.route = ROUTE_HEADER;
            in_len_in    = 1'b1;
            digit_cnt_in = '0;
            length_in    = '0;
            window_in    = '0;
            fill_in      = '0;
         end else begin
            window_in = {window_ff[23:0], req_tdata};
            if (fill_ff < 3'(WINDOW_BYTES)) begin
               fill_in = fill_ff + 3'd1;
            end
         end
      end
   end

   // Output register with one skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = in_take;
         end
      end else if (in_take) begin
         // hold the new beat behind the stalled one
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         fill_ff       <= '0;
         in_len_ff     <= 1'b0;
         digit_cnt_ff  <= '0;
         length_ff     <= '0;
         pay_active_ff <= 1'b0;
         remain_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            window_ff     <= window_in;
            fill_ff       <= fill_in;
            in_len_ff     <= in_len_in;
            digit_cnt_ff  <= digit_cnt_in;
            length_ff     <= length_in;
            pay_active_ff <= pay_active_in;
            remain_ff     <= remain_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.payload_length, out_ff.data_byte};
   assign rsp_tuser  = {out_ff.header_done, out_ff.route};
   assign rsp_tlast  = out_ff.payload_last;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while output register empty");

   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(in_len_ff && pay_active_ff))
      else $error("length field and payload active together");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'(WINDOW_BYTES))
      else $error("prefix window fill out of range");

   a_digit_limit: assert property (@(posedge clock) disable iff (reset)
      digit_cnt_ff <= DCNT_W'(MAX_DIGITS))
      else $error("digit count past limit");

   a_hend_is_header: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.header_done) |-> (out_ff.route == ROUTE_HEADER))
      else $error("header end flagged on a non-header beat");
`endif

endmodule

/* sim/ipd_fd_sb_pkg.sv */
// Scoreboard class for the +IPD frame demultiplexer: per-byte route prediction and result check.
package ipd_fd_sb_pkg;
   import ipd_fd_pkg::*;

   localparam int DIGIT_LIMIT = 15;
   localparam int LEN_BITS    = 16;
   localparam logic [LEN_BITS-1:0] LEN_CEIL = '1;

   class frame_route_board;
      logic [31:0]         window;
      int unsigned         window_fill;
      bit                  in_length;
      int unsigned         ndigits;
      logic [LEN_BITS-1:0] length_acc;
      bit                  in_payload;
      logic [LEN_BITS-1:0] remaining;
      rsp_type             routed_q[$];
      int                  errors;

      function new();
         window      = '0;
         window_fill = 0;
         in_length   = 1'b0;
         ndigits     = 0;
         length_acc  = '0;
         in_payload  = 1'b0;
         remaining   = '0;
         errors      = 0;
      endfunction

      function int pending();
         return routed_q.size();
      endfunction

      task report(input string what, input longint got, input longint want);
         errors++;
         $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
      endtask

      // Work out the route of one accepted byte and queue it.
      task note_byte(input logic [7:0] b);
         rsp_type     want;
         logic [31:0] grown;
         want = '0;
         want.data_byte = b;
         want.route = ROUTE_TEXT;
         if (in_payload) begin
            want.route = ROUTE_PAYLOAD;
            if (remaining != 0) remaining--;
            if (remaining == 0) begin
               in_payload = 1'b0;
               want.payload_last = 1'b1;
            end
         end else if (in_length) begin
            want.route = ROUTE_HEADER;
            if (b == COLON_CHAR) begin
               want.header_done = 1'b1;
               want.payload_length = length_acc;
               remaining   = length_acc;
               in_payload  = (length_acc != 0);
               in_length   = 1'b0;
               window      = '0;
               window_fill = 0;
            end else if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
               // digits past the limit are dropped
               if (ndigits < DIGIT_LIMIT) begin
                  grown = {16'd0, length_acc} * 32'd10 + {24'd0, b - DIGIT_ZERO};
                  length_acc = (grown > {16'd0, LEN_CEIL}) ? LEN_CEIL : grown[LEN_BITS-1:0];
                  ndigits++;
               end
            end else begin
               in_length   = 1'b0;
               window      = '0;
               window_fill = 0;
            end
         end else if (window_fill >= 4 && window == PREFIX_HEAD && b == PREFIX_TAIL) begin
            want.route  = ROUTE_HEADER;
            in_length   = 1'b1;
            ndigits     = 0;
            length_acc  = '0;
            window      = '0;
            window_fill = 0;
         end else begin
            window = {window[23:0], b};
            if (window_fill < 4) window_fill++;
         end
         routed_q.push_back(want);
      endtask

      task check_beat(input rsp_type got);
         rsp_type want;
         if (routed_q.size() == 0) begin
            report("beat with nothing pending", got, 0);
            return;
         end
         want = routed_q.pop_front();
         if (got.data_byte != want.data_byte)
            report("data_byte", got.data_byte, want.data_byte);
         if (got.route != want.route)
            report("route", got.route, want.route);
         if (got.payload_last != want.payload_last)
            report("payload_last", got.payload_last, want.payload_last);
         if (got.header_done != want.header_done)
            report("header_done", got.header_done, want.header_done);
         if (got.payload_length != want.payload_length)
            report("payload_length", got.payload_length, want.payload_length);
      endtask
   endclass

endpackage

/* sim/tb.sv */
// Testbench top for ipd_frame_demux_core: byte stream driver, result monitor and run control.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ipd_fd_pkg::*;
   import ipd_fd_sb_pkg::*;

   localparam longint CYCLE_LIMIT = 10_000_000;
   localparam string  PREFIX      = "+IPD,";
   localparam string  TEXT_CHARS  = "+IPD,:0123456789\r\nOK";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] data_byte, [23:8] payload_length
   logic [2:0]  rsp_tuser;           // [1:0] route, [2] header_done
   logic        rsp_tlast;           // payload_last

   frame_route_board board = new();
   rsp_type          rsp_seen;
   logic [7:0]       tx_bytes[$];
   int               sent_count = 0;
   int               calm_left = 0;
   int               hold_left = 0;
   int               free_left = 0;
   int               ready_pick;
   longint           cycle_count = 0;

   ipd_frame_demux_core #(
      .MAX_DIGITS  (DIGIT_LIMIT),
      .LENGTH_BITS (LEN_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver back-pressure: short stalls, a few long ones, and stall-free stretches.
   always @(posedge clock) begin
      if (free_left > 0) begin
         free_left--;
         rsp_tready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 3)
            free_left = $urandom_range(50, 300);
         else if (ready_pick < 25)
            hold_left = $urandom_range(1, 3);
         else if (ready_pick < 28)
            hold_left = $urandom_range(8, 30);
         rsp_tready <= (hold_left == 0);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen.data_byte      = rsp_tdata[7:0];
         rsp_seen.payload_length = rsp_tdata[23:8];
         rsp_seen.route          = route_type'(rsp_tuser[1:0]);
         rsp_seen.header_done    = rsp_tuser[2];
         rsp_seen.payload_last   = rsp_tlast;
         board.check_beat(rsp_seen);
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(40, 200);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Half full-range bytes, half from the prefix, digit, colon and response-text characters.
   function automatic logic [7:0] any_char();
      if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
      return TEXT_CHARS[$urandom_range(0, TEXT_CHARS.len() - 1)];
   endfunction

   function automatic logic [7:0] abort_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == COLON_CHAR || (b >= DIGIT_ZERO && b <= DIGIT_NINE))
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic string lead_in();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return PREFIX;
      if (r < 90) return "++IPD,";
      return "+IPD+IPD,";
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
   endfunction

   function automatic void push_frame(input string lead, input string digits,
                                      input int unsigned n_payload);
      push_text(lead);
      push_text(digits);
      tx_bytes.push_back(COLON_CHAR);
      repeat (n_payload) tx_bytes.push_back(any_char());
   endfunction

   task automatic send_byte(input logic [7:0] b, input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_byte(b);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_queue();
      logic [7:0] b;
      while (tx_bytes.size() > 0) begin
         b = tx_bytes.pop_front();
         send_byte(b, pick_gap());
         sent_count++;
      end
   endtask

   // Hold the sender until every routed byte has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() > 0);
   endtask

   task automatic run_mix(input int n_items);
      int          stop_at;
      int          pick;
      int unsigned n;
      string       digits;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0)
               n = 0;
            else if ($urandom_range(0, 9) == 0)
               n = $urandom_range(25, 200);
            else
               n = $urandom_range(1, 24);
            digits = $sformatf("%0d", n);
            if (n == 0 && $urandom_range(0, 1)) begin
               digits = "";
            end else if ($urandom_range(0, 9) == 0) begin
               // fill the digit limit with leading zeros, the tail is ignored
               while (digits.len() < DIGIT_LIMIT) digits = {"0", digits};
               repeat ($urandom_range(1, 4))
                  digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end else begin
               repeat ($urandom_range(0, 2)) digits = {"0", digits};
            end
            push_frame(lead_in(), digits, n);
         end else if (pick < 65) begin
            repeat ($urandom_range(1, 10)) tx_bytes.push_back(any_char());
         end else if (pick < 80) begin
            push_text(PREFIX);
            repeat ($urandom_range(0, 3))
               push_text($sformatf("%0d", $urandom_range(0, 9)));
            tx_bytes.push_back(abort_char());
            if ($urandom_range(0, 1)) tx_bytes.push_back(COLON_CHAR);
         end else if (pick < 98) begin
            push_text(PREFIX.substr(0, $urandom_range(0, 3)));
            tx_bytes.push_back(any_char());
         end
         send_queue();
         if (pick >= 98) drain_results();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes, empty length, abort, short payload
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      push_text("+IPD,:");
      push_text("+IPD,7A");
      push_frame(PREFIX, "2", 2);
      send_queue();
      drain_results();

      run_mix(800);

      run_mix(850);

      drain_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
